// ===== hdl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and codes for the base64 stream decoder: character classes,
// message status codes and the beats that travel between front and back.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// ASCII code of the pad character
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Bit counts of one output byte and one alphabet character
	localparam logic [3:0] BYTE_BITS   = 4'd8;
	localparam logic [3:0] SEXTET_BITS = 4'd6;

	// Character classes produced by the front
	localparam logic [1:0] CLS_DATA = 2'd0;
	localparam logic [1:0] CLS_PAD  = 2'd1;
	localparam logic [1:0] CLS_BAD  = 2'd2;

	// Message status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_BAD_PAD  = 2'd2;
	localparam logic [1:0] ST_BAD_LEN  = 2'd3;

	// Classified character beat, front to back
	typedef struct packed {
		logic       last;
		logic [1:0] cls;
		logic [5:0] sextet;
	} item_t;

	// Result beat, back to output queue
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       done_res;
		logic [1:0] status;
	} res_t;

endpackage

// ===== hdl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Front classifier: maps one ASCII character to its class and 6-bit value
// through the standard alphabet.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic [7:0]      char_code,
	input  logic            last,
	output b64d_pkg::item_t item
);
	import b64d_pkg::*;

	logic [7:0] sext_wide;
	logic [1:0] cls;

	// Alphabet lookup: A-Z, a-z, 0-9, '+', '/', then pad, else invalid
	always_comb begin
		sext_wide = 8'd0;
		cls       = CLS_BAD;
		if (char_code >= 8'h41 && char_code <= 8'h5A) begin
			sext_wide = char_code - 8'h41;
			cls       = CLS_DATA;
		end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
			sext_wide = char_code - 8'h61 + 8'd26;
			cls       = CLS_DATA;
		end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
			sext_wide = char_code - 8'h30 + 8'd52;
			cls       = CLS_DATA;
		end else if (char_code == 8'h2B) begin
			sext_wide = 8'd62;
			cls       = CLS_DATA;
		end else if (char_code == 8'h2F) begin
			sext_wide = 8'd63;
			cls       = CLS_DATA;
		end else if (char_code == PAD_CHAR) begin
			cls = CLS_PAD;
		end
	end

	assign item.last   = last;
	assign item.cls    = cls;
	assign item.sextet = sext_wide[5:0];

endmodule

// ===== hdl/b64d_fifo.sv =====
// ----------------------------------------------------------------------------
// b64d_fifo
// Small register queue with push/full and pop/empty handshakes. Used between
// front and back, and as the result queue.
// ----------------------------------------------------------------------------
module b64d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_en;
	logic             rd_en;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign dout  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Back end: sextet accumulator, pad counting, error tracking and end of
// message status. Takes one classified beat per cycle when the result queue
// has room.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  b64d_pkg::item_t in_item,
	output logic            in_pop,
	input  logic            out_full,
	output logic            out_push,
	output b64d_pkg::res_t  out_res
);
	import b64d_pkg::*;

	logic [11:0] buf_q;
	logic [3:0]  cnt_q;
	logic [1:0]  pad_q;
	logic [1:0]  err_q;

	logic [11:0] buf_n;
	logic [3:0]  cnt_n;
	logic [3:0]  cnt_sum;
	logic [1:0]  pad_n;
	logic [1:0]  err_n;
	logic        have_byte;
	logic [7:0]  byte_val;
	logic [1:0]  fin_status;
	logic        go;

	assign go     = in_valid && !out_full;
	assign in_pop = go;

	// Next state for one character
	always_comb begin
		buf_n     = buf_q;
		cnt_n     = cnt_q;
		pad_n     = pad_q;
		err_n     = err_q;
		have_byte = 1'b0;
		byte_val  = 8'd0;
		cnt_sum   = cnt_q + SEXTET_BITS;
		unique case (in_item.cls)
			CLS_BAD: begin
				err_n = ST_BAD_CHAR;
			end
			CLS_PAD: begin
				if (err_q == ST_OK) begin
					if (pad_q >= 2'd2) begin
						err_n = ST_BAD_PAD;
					end else begin
						pad_n = pad_q + 2'd1;
					end
				end
			end
			CLS_DATA: begin
				if (err_q == ST_OK) begin
					if (pad_q != 2'd0) begin
						err_n = ST_BAD_PAD;
					end else begin
						buf_n = {buf_q[5:0], in_item.sextet};
						cnt_n = cnt_sum;
						if (cnt_sum >= BYTE_BITS) begin
							cnt_n     = cnt_sum - BYTE_BITS;
							have_byte = 1'b1;
							// leftover count is 0, 2 or 4 here
							case (cnt_n)
								4'd2:    byte_val = buf_n[9:2];
								4'd4:    byte_val = buf_n[11:4];
								default: byte_val = buf_n[7:0];
							endcase
						end
					end
				end
			end
			default: begin
				err_n = ST_BAD_CHAR;
			end
		endcase
	end

	// Closing status: leftover bits must equal twice the pad count
	always_comb begin
		fin_status = err_n;
		if (err_n == ST_OK && cnt_n != {1'b0, pad_n, 1'b0}) begin
			fin_status = ST_BAD_LEN;
		end
	end

	assign out_push           = go && (have_byte || in_item.last);
	assign out_res.data_byte  = have_byte ? byte_val : 8'd0;
	assign out_res.byte_valid = have_byte;
	assign out_res.done_res   = in_item.last;
	assign out_res.status     = in_item.last ? fin_status : ST_OK;

	// Message state; cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
			pad_q <= '0;
			err_q <= ST_OK;
		end else if (go) begin
			if (in_item.last) begin
				buf_q <= '0;
				cnt_q <= '0;
				pad_q <= '0;
				err_q <= ST_OK;
			end else begin
				buf_q <= buf_n;
				cnt_q <= cnt_n;
				pad_q <= pad_n;
				err_q <= err_n;
			end
		end
	end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Standard-alphabet base64 decoder, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: char_code and last, taken when push is high and full low.
//   Result channel: data_byte, byte_valid, done_res and status show the
//   oldest result while empty is low; pop high with empty low takes it.
//   A character gives a result when it completes a byte, when it carries
//   last, or both; other characters give none.
//   Path: a character beat is held in the middle queue, its result is
//   pushed into the result queue, and from there it can be popped.
//   Throughput: one character per cycle while the result queue has room,
//   set by the accumulator update in the back end.
//   The front classifies characters into a MID_DEPTH queue; the back drains
//   it into an OUT_DEPTH result queue. When the receiver stops popping, the
//   result queue fills, the back holds, and full rises once the middle queue
//   is full. No beat is dropped.
//   A nonzero status on the done beat flags the whole message bad; bytes
//   already delivered for it must be dropped by the receiver.
//   Reset empties both queues and clears the accumulator, pad count and error.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       done_res,
	output logic [1:0] status
);
	import b64d_pkg::*;

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(res_t);

	item_t front_item;
	item_t mid_item;
	logic  mid_empty;
	logic  mid_pop;
	logic  out_full;
	logic  out_push;
	res_t  back_res;
	res_t  head_res;

	b64d_front u_front (
		.char_code (char_code),
		.last      (last),
		.item      (front_item)
	);

	b64d_fifo #(.WIDTH(ITEM_W), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.full   (full),
		.pop    (mid_pop),
		.dout   (mid_item),
		.empty  (mid_empty)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_item  (mid_item),
		.in_pop   (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_res  (back_res)
	);

	b64d_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (back_res),
		.full   (out_full),
		.pop    (pop),
		.dout   (head_res),
		.empty  (empty)
	);

	assign data_byte  = head_res.data_byte;
	assign byte_valid = head_res.byte_valid;
	assign done_res   = head_res.done_res;
	assign status     = head_res.status;

	// Every result carries a byte, a done mark, or both
	a_res_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (byte_valid || done_res))
		else $error("result beat with neither byte nor done");

	// Status only rides on the done beat
	a_status_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> done_res)
		else $error("nonzero status on a non-final beat");

	// A character or pad error freezes the accumulator: no byte with it
	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_BAD_CHAR || status == ST_BAD_PAD)) |-> !byte_valid)
		else $error("byte delivered with a character or pad error");

	// Byte output is zero whenever no byte is flagged
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (data_byte == 8'd0))
		else $error("nonzero data without byte_valid");

endmodule
